@@ rtl/assert_macros.svh @@
// assertion macros used by the gaussian tap weight generator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/gtw_pkg.sv @@
// package for the gaussian tap weight generator
// constants, state enum, exponent table function
package gtw_pkg;

    localparam int MaxSamples = 32;
    localparam int HiInt = (MaxSamples - 1) < 31 ? (MaxSamples - 1) : 31;
    localparam logic [12:0] RadLo = 13'd26;
    localparam logic [12:0] RadHi = 13'(HiInt * 256);
    localparam logic [12:0] ExpK = 13'd6168;
    localparam int NumPairs = HiInt + 1;
    localparam int PairW = $clog2(NumPairs);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_W0,
        ST_W1,
        ST_DIV0,
        ST_DIV1,
        ST_NORM0,
        ST_NORM1,
        ST_EMIT
    } t_state;

    // 2^-(f/256) in q16, rounded, computed by repeated fixed-point multiplication
    function automatic logic [16:0] exp_rom(input logic [7:0] f);
        logic [63:0] v;
        logic [16:0] res;
        v = 64'd1 << 32;
        res = 17'd65536;
        for (int k = 1; k < 256; k++) begin
            v = ((v * 64'd4283353945) + (64'd1 << 31)) >> 32;
            if (k == int'(f)) begin
                res = 17'((v + 64'h8000) >> 16);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/gaussian_tap_weight_generator.sv @@
// gaussian tap weight generator: takes a blur radius, emits r+1 tap pairs
// each pair: up to three divides (two exponents, offset) plus a step state
// each tap: one normalize divide plus the NORM1 and EMIT states; one radius at a time
// reset: synchronous active low, returns to idle and drops busy and strobe
`include "assert_macros.svh"
module gaussian_tap_weight_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [12:0]        i_blur_radius,
    output logic               o_valid,
    output logic signed [15:0] o_tap_offset,
    output logic [15:0]        o_tap_weight,
    output logic               o_last_tap
);
    localparam int PW = gtw_pkg::PairW;

    gtw_pkg::t_state r_state, n_state;
    logic [12:0] r_s;
    logic [5:0]  r_r;
    logic signed [6:0] r_i;
    logic [PW-1:0] r_k, r_n;
    logic [16:0] r_w0, r_w1;
    logic [22:0] r_sum;
    logic [17:0] r_tot [gtw_pkg::NumPairs];
    logic signed [15:0] r_off [gtw_pkg::NumPairs];
    logic [15:0] r_wt;
    logic        r_div_busy;
    logic [25:0] r_s2;

    logic        w_dstart;
    logic [47:0] w_num, w_den, w_quot;
    logic        w_ddone;
    logic [5:0]  w_ax;
    logic [17:0] w_t;
    logic [16:0] w_wgt;
    logic [12:0] w_sin;

    gtw_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    // operands for the shared divider
    always_comb begin
        w_ax = (r_state == gtw_pkg::ST_W1) ? 6'(r_i + 7'sd1) : 6'(r_i);
        if (r_i < 0 && r_state == gtw_pkg::ST_W0) w_ax = 6'(-r_i);
        if (r_i + 7'sd1 < 0 && r_state == gtw_pkg::ST_W1) w_ax = 6'(-(r_i + 7'sd1));
        w_t = {1'b0, r_w0} + {1'b0, r_w1};
        w_num = '0;
        w_den = 48'd1;
        case (r_state)
            gtw_pkg::ST_W0, gtw_pkg::ST_W1: begin
                w_num = 48'(gtw_pkg::ExpK) * 48'(w_ax) * 48'(w_ax) * 48'd65536
                      + 48'(r_s2 >> 1);
                w_den = 48'(r_s2);
            end
            gtw_pkg::ST_DIV0: begin
                w_num = 48'(r_w1) * 48'd1024 + 48'(w_t >> 1);
                w_den = 48'(w_t);
            end
            gtw_pkg::ST_NORM0: begin
                w_num = 48'(r_tot[r_k]) * 48'd65536 + 48'(r_sum >> 1);
                w_den = 48'(r_sum);
            end
            default: ;
        endcase
    end

    // exponent from quotient, and the clamped blur radius
    always_comb begin
        w_wgt = '0;
        if (w_quot[47:8] < 40'd17)
            w_wgt = gtw_pkg::exp_rom(w_quot[7:0]) >> w_quot[12:8];
        w_sin = i_blur_radius;
        if (w_sin < gtw_pkg::RadLo) w_sin = gtw_pkg::RadLo;
        if (w_sin > gtw_pkg::RadHi) w_sin = gtw_pkg::RadHi;
    end

    assign w_dstart = !r_div_busy && (r_state == gtw_pkg::ST_W0 || r_state == gtw_pkg::ST_W1
                      || r_state == gtw_pkg::ST_DIV0 || r_state == gtw_pkg::ST_NORM0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gtw_pkg::ST_IDLE:  if (start) n_state = gtw_pkg::ST_CLAMP;
            gtw_pkg::ST_CLAMP: n_state = gtw_pkg::ST_W0;
            gtw_pkg::ST_W0:    if (w_ddone) n_state = gtw_pkg::ST_W1;
            gtw_pkg::ST_W1:    if (w_ddone || r_i == $signed({1'b0, r_r}))
                                   n_state = gtw_pkg::ST_DIV0;
            gtw_pkg::ST_DIV0:  if (w_ddone || w_t == '0) n_state = gtw_pkg::ST_DIV1;
            gtw_pkg::ST_DIV1:
                if (r_i + 7'sd2 > $signed({1'b0, r_r})) n_state = gtw_pkg::ST_NORM0;
                else n_state = gtw_pkg::ST_W0;
            gtw_pkg::ST_NORM0: if (w_ddone) n_state = gtw_pkg::ST_NORM1;
            gtw_pkg::ST_NORM1: n_state = gtw_pkg::ST_EMIT;
            gtw_pkg::ST_EMIT:
                if (r_k == r_n) n_state = gtw_pkg::ST_IDLE;
                else n_state = gtw_pkg::ST_NORM0;
            default: n_state = gtw_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gtw_pkg::ST_IDLE;
            r_div_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_dstart && !(r_state == gtw_pkg::ST_W1 && r_i == $signed({1'b0, r_r}))
                && !(r_state == gtw_pkg::ST_DIV0 && w_t == '0))
                r_div_busy <= 1'b1;
            else if (w_ddone)
                r_div_busy <= 1'b0;
        end
        case (r_state)
            gtw_pkg::ST_IDLE: begin
                r_s  <= w_sin;
                r_s2 <= 26'(w_sin) * 26'(w_sin);
            end
            gtw_pkg::ST_CLAMP: begin
                r_r   <= (r_s + 13'd255) > 13'(gtw_pkg::HiInt * 256 + 255)
                         ? 6'(gtw_pkg::HiInt) : 6'((r_s + 13'd255) >> 8);
                r_i   <= -$signed({1'b0, 6'((r_s + 13'd255) >> 8)});
                r_k   <= '0;
                r_sum <= '0;
                r_w1  <= '0;
            end
            gtw_pkg::ST_W0: if (w_ddone) r_w0 <= w_wgt;
            gtw_pkg::ST_W1: begin
                if (r_i == $signed({1'b0, r_r})) r_w1 <= '0;
                else if (w_ddone) r_w1 <= w_wgt;
            end
            gtw_pkg::ST_DIV0: begin
                if (w_t == '0) begin
                    r_off[r_k] <= 16'(r_i) <<< 10;
                end else if (w_ddone) begin
                    r_off[r_k] <= (16'(r_i) <<< 10) + 16'(w_quot);
                end
                r_tot[r_k] <= w_t;
            end
            gtw_pkg::ST_DIV1: begin
                r_sum <= r_sum + 23'(r_tot[r_k]);
                r_i   <= r_i + 7'sd2;
                // r_n keeps the index of the final pair
                if (r_i + 7'sd2 > $signed({1'b0, r_r})) begin
                    r_n <= r_k;
                    r_k <= '0;
                end else begin
                    r_k <= r_k + PW'(1);
                end
            end
            gtw_pkg::ST_NORM0:
                if (w_ddone) r_wt <= (w_quot > 48'd65535) ? 16'hFFFF : 16'(w_quot);
            gtw_pkg::ST_EMIT: r_k <= r_k + PW'(1);
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        busy         = (r_state != gtw_pkg::ST_IDLE);
        o_valid      = (r_state == gtw_pkg::ST_EMIT);
        o_tap_offset = r_off[r_k];
        o_tap_weight = r_wt;
        o_last_tap   = (r_k == r_n);
    end

    `ASSERT_IMPLY(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_valid && o_last_tap, !busy)
endmodule

@@ rtl/gtw_divider.sv @@
// restoring divider, one quotient bit per cycle
// no dependencies
module gtw_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [47:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [47:0] r_quot, n_quot;
    logic [48:0] r_rem, n_rem;
    logic [47:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] w_try;

    // shift in one numerator bit, trial subtract
    always_comb begin
        w_try  = {r_rem[47:0], r_quot[47]};
        n_quot = {r_quot[46:0], 1'b0};
        n_rem  = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem     = w_try - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
